FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on the rising clock edge, left out under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: sv/ssram_pkg.sv
// ----------------------------------------------------------------------------
// ssram_pkg
// types and constants shared by the serial sram slave modules
// ----------------------------------------------------------------------------
`default_nettype none

package ssram_pkg;

   localparam int MEM_BYTES = 131072;
   localparam int MEM_AW    = $clog2(MEM_BYTES);
   localparam int ADDR_W    = 24;
   localparam int DIV_W     = ADDR_W + 1;

   localparam logic MEM_POW2 = ((MEM_BYTES & (MEM_BYTES - 1)) == 0);
   localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'(MEM_BYTES - 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MEM_BYTES - 1);
   localparam logic [DIV_W-1:0]  DIV_LAST  = DIV_W'(MEM_BYTES);
   localparam logic [DIV_W-1:0]  DIV_START = DIV_W'(MEM_BYTES) << (ADDR_W - MEM_AW);

   localparam logic [7:0] CMD_READ  = 8'h03;
   localparam logic [7:0] CMD_WRITE = 8'h02;

   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam int OPQ_DEPTH = 4;
   localparam int OPQ_PW    = $clog2(OPQ_DEPTH);
   localparam int OPQ_CW    = OPQ_PW + 1;

   localparam int OUT_DEPTH = 2;
   localparam int OUT_PW    = $clog2(OUT_DEPTH);
   localparam int OUT_CW    = OUT_PW + 1;

   typedef struct packed {
      logic       select;
      logic [7:0] mosi_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] miso_byte;
      logic       data_valid;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [MEM_AW-1:0] addr;
      logic [7:0]        data;
   } op_item_type;

endpackage

`default_nettype wire

FILE: sv/spi_sram_byte_protocol_slave.sv
// ----------------------------------------------------------------------------
// spi_sram_byte_protocol_slave
// path: a pushed byte's result goes via the op queue, read stage and result queue
// throughput: one byte per cycle while full is low; full is high while the op queue
// is full and, with a size that is not a power of two, while the address is reduced
// reset: synchronous, returns to the command phase; memory is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module spi_sram_byte_protocol_slave
   import ssram_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire req_item_type req_item,
   output logic              empty,
   input  wire logic         pop,
   output rsp_item_type      rsp_item
);

   logic        q_full;
   logic        q_push;
   op_item_type q_wr_item;
   logic        q_pop;
   op_item_type q_rd_item;
   logic        q_empty;

   ssram_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (q_wr_item)
   );

   ssram_opq u_opq (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_item (q_wr_item),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .rd_item (q_rd_item),
      .q_empty (q_empty)
   );

   ssram_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_empty (q_empty),
      .op_item  (q_rd_item),
      .op_pop   (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_item (rsp_item)
   );

endmodule

`default_nettype wire

FILE: sv/ssram_front.sv
// ----------------------------------------------------------------------------
// ssram_front
// protocol sequencer: command, address and data phases, one memory op per byte
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ssram_front
   import ssram_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire req_item_type req_item,
   input  wire logic         q_full,
   output logic              q_push,
   output op_item_type       q_item
);

   localparam logic [2:0] ST_CMD    = 3'd0;
   localparam logic [2:0] ST_ADDR0  = 3'd1;
   localparam logic [2:0] ST_ADDR1  = 3'd2;
   localparam logic [2:0] ST_ADDR2  = 3'd3;
   localparam logic [2:0] ST_DATA   = 3'd4;
   localparam logic [2:0] ST_IGNORE = 3'd5;
   localparam logic [2:0] ST_REDUCE = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [7:0]        cmd_ff, cmd_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [ADDR_W-1:0] addr_shift;
   logic              accept;

   assign full       = q_full | (state_ff == ST_REDUCE);
   assign accept     = push & ~full;
   assign addr_shift = {addr_ff[ADDR_W-9:0], req_item.mosi_byte};
   assign q_push     = accept;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      div_in       = div_ff;
      q_item.kind  = OP_NONE;
      q_item.addr  = addr_ff[MEM_AW-1:0];
      q_item.data  = req_item.mosi_byte;
      if (accept) begin
         if (!req_item.select) begin
            state_in = ST_CMD;
         end else begin
            unique case (state_ff)
               ST_CMD: begin
                  cmd_in = req_item.mosi_byte;
                  if (req_item.mosi_byte == CMD_READ || req_item.mosi_byte == CMD_WRITE) begin
                     addr_in  = '0;
                     state_in = ST_ADDR0;
                  end else begin
                     state_in = ST_IGNORE;
                  end
               end
               ST_ADDR0: begin
                  addr_in  = addr_shift;
                  state_in = ST_ADDR1;
               end
               ST_ADDR1: begin
                  addr_in  = addr_shift;
                  state_in = ST_ADDR2;
               end
               ST_ADDR2: begin
                  div_in = DIV_START;
                  if (MEM_POW2) begin
                     addr_in  = addr_shift & ADDR_MASK;
                     state_in = ST_DATA;
                  end else begin
                     addr_in  = addr_shift;
                     state_in = ST_REDUCE;
                  end
               end
               ST_DATA: begin
                  q_item.kind = (cmd_ff == CMD_READ) ? OP_READ : OP_WRITE;
                  addr_in     = (addr_ff == ADDR_LAST) ? '0 : addr_ff + 1'b1;
               end
               ST_IGNORE: begin
                  state_in = ST_IGNORE;
               end
               default: begin
                  state_in = ST_CMD;
               end
            endcase
         end
      end else if (state_ff == ST_REDUCE) begin
         // restoring reduction, one shifted multiple of the size per cycle
         if ({1'b0, addr_ff} >= div_ff) begin
            addr_in = addr_ff - div_ff[ADDR_W-1:0];
         end
         if (div_ff == DIV_LAST) begin
            state_in = ST_DATA;
         end else begin
            div_in = div_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CMD;
         cmd_ff   <= '0;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
         addr_ff  <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
   end

   `ASSERT_NEXT(a_addr_phase_done, clock, reset,
      accept && req_item.select && state_ff == ST_ADDR2,
      state_ff == ST_DATA || state_ff == ST_REDUCE)
   `ASSERT_IMPLIES(a_data_addr_range, clock, reset, state_ff == ST_DATA, addr_ff <= ADDR_LAST)

endmodule

`default_nettype wire

FILE: sv/ssram_opq.sv
// ----------------------------------------------------------------------------
// ssram_opq
// short queue of memory ops between the sequencer and the memory side
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ssram_opq
   import ssram_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        wr_en,
   input  wire op_item_type wr_item,
   output logic             q_full,
   input  wire logic        rd_en,
   output op_item_type      rd_item,
   output logic             q_empty
);

   op_item_type       slot_ff [OPQ_DEPTH];
   logic [OPQ_PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OPQ_PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OPQ_CW-1:0] cnt_ff, cnt_in;
   logic              do_wr, do_rd;

   assign q_full  = (cnt_ff == OPQ_CW'(OPQ_DEPTH));
   assign q_empty = (cnt_ff == '0);
   assign do_wr   = wr_en & ~q_full;
   assign do_rd   = rd_en & ~q_empty;
   assign rd_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + OPQ_CW'(do_wr) - OPQ_CW'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

   `ASSERT_ALWAYS(a_opq_count_bound, clock, reset, cnt_ff <= OPQ_CW'(OPQ_DEPTH))

endmodule

`default_nettype wire

FILE: sv/ssram_back.sv
// ----------------------------------------------------------------------------
// ssram_back
// memory array, registered read and the result queue
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ssram_back
   import ssram_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        op_empty,
   input  wire op_item_type op_item,
   output logic             op_pop,
   input  wire logic        pop,
   output logic             empty,
   output rsp_item_type     rsp_item
);

   logic [7:0]        mem [MEM_BYTES];
   logic [7:0]        rdata_ff;
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_read_ff;
   rsp_item_type      out_ff [OUT_DEPTH];
   rsp_item_type      out_new;
   logic [OUT_PW-1:0] out_wr_ff, out_wr_in;
   logic [OUT_PW-1:0] out_rd_ff, out_rd_in;
   logic [OUT_CW-1:0] out_cnt_ff, out_cnt_in;
   logic [OUT_CW:0]   occ_after;
   logic              out_pop;
   logic              issue;

   assign empty    = (out_cnt_ff == '0);
   assign out_pop  = pop & ~empty;
   assign rsp_item = out_ff[out_rd_ff];

   // occupancy once this cycle's pop and the op in flight are counted
   assign occ_after = (OUT_CW + 1)'(out_cnt_ff) + (OUT_CW + 1)'(s1_valid_ff)
                    - (OUT_CW + 1)'(out_pop);
   assign issue     = ~op_empty & (occ_after < (OUT_CW + 1)'(OUT_DEPTH));
   assign op_pop    = issue;

   always_comb begin
      s1_valid_in        = issue;
      out_new.miso_byte  = s1_read_ff ? rdata_ff : 8'h00;
      out_new.data_valid = s1_read_ff;
      out_wr_in          = s1_valid_ff ? out_wr_ff + 1'b1 : out_wr_ff;
      out_rd_in          = out_pop ? out_rd_ff + 1'b1 : out_rd_ff;
      out_cnt_in         = out_cnt_ff + OUT_CW'(s1_valid_ff) - OUT_CW'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (issue && op_item.kind == OP_WRITE) begin
         mem[op_item.addr] <= op_item.data;
      end
      if (issue && op_item.kind == OP_READ) begin
         rdata_ff <= mem[op_item.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_wr_ff   <= '0;
         out_rd_ff   <= '0;
         out_cnt_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_wr_ff   <= out_wr_in;
         out_rd_ff   <= out_rd_in;
         out_cnt_ff  <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_read_ff <= (op_item.kind == OP_READ);
      end
      if (s1_valid_ff) begin
         out_ff[out_wr_ff] <= out_new;
      end
   end

   `ASSERT_IMPLIES(a_result_has_room, clock, reset, s1_valid_ff,
      out_cnt_ff != OUT_CW'(OUT_DEPTH) || out_pop)
   `ASSERT_ALWAYS(a_out_count_bound, clock, reset, out_cnt_ff <= OUT_CW'(OUT_DEPTH))

endmodule

`default_nettype wire
